// ===== hw/rtl/tpf_pkg.sv =====
// Shared types, constants and lookup functions for the typed packet framer.
package tpf_pkg;

  localparam int MAX_PACKET_BYTES = 256;

  // Payload byte count: element count shifted by up to three.
  localparam int NB_W  = 11;
  // Bytes still expected; holds up to MAX_PACKET_BYTES - 8.
  localparam int REM_W = $clog2(MAX_PACKET_BYTES - 7);

  localparam logic [3:0] TYPE_MAX = 4'd9;

  localparam logic [7:0] CHAR_K  = 8'h4B;
  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_DATA  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_REFUSE = 2'd1,
    STATUS_ORPHAN = 2'd2
  } status_t;

  // Output bytes caused by one input item, first byte in bytes[0].
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [2:0]      last_idx;
    logic            pkt_end;
    status_t         status;
  } burst_t;

  // High nibble of the info word for a type code.
  function automatic logic [3:0] type_nibble(input logic [3:0] code);
    logic [3:0] nib;
    unique case (code)
      4'd8:    nib = 4'hA;
      4'd9:    nib = 4'hB;
      default: nib = (code > TYPE_MAX) ? 4'h0 : code;
    endcase
    return nib;
  endfunction

  // log2 of the element size for a type code.
  function automatic logic [1:0] size_shift(input logic [3:0] code);
    logic [1:0] sh;
    unique case (code)
      4'd8:    sh = 2'd2;
      4'd9:    sh = 2'd3;
      default: sh = code[1:0];
    endcase
    return sh;
  endfunction

endpackage

// ===== hw/rtl/tpf_decode.sv =====
// Item decode, framer state and the pending burst register.
module tpf_decode
  import tpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  kind_t       kind,
  input  logic [7:0]  element_count,
  input  logic [3:0]  data_type,
  input  logic [7:0]  payload_byte,
  input  logic        take,
  output logic        pend_valid,
  output burst_t      pend
);

  logic [15:0]      sequence_count;
  logic [15:0]      sequence_count_next;
  logic [REM_W-1:0] bytes_remaining;
  logic [REM_W-1:0] bytes_remaining_next;
  logic             packet_open;
  logic             packet_open_next;
  logic             accept;
  burst_t           burst;
  logic [NB_W-1:0]  nbytes;
  logic             type_ok;
  logic             oversize;
  logic [15:0]      info;

  assign in_ready = !pend_valid || take;
  assign accept   = in_valid && in_ready;

  assign type_ok  = data_type <= TYPE_MAX;
  assign nbytes   = NB_W'(element_count) << size_shift(data_type);
  assign oversize = 32'(nbytes) > 32'(MAX_PACKET_BYTES - 8);
  assign info     = {type_nibble(data_type), 12'(nbytes)};

  always_comb begin
    burst                = '0;
    burst.status         = STATUS_OK;
    sequence_count_next  = sequence_count;
    bytes_remaining_next = bytes_remaining;
    packet_open_next     = packet_open;
    unique case (kind)
      KIND_BEGIN: begin
        if (!type_ok || oversize) begin
          burst.status = STATUS_REFUSE;
        end else begin
          sequence_count_next = sequence_count + 16'd1;
          burst.bytes[0] = CHAR_K;
          burst.bytes[1] = CHAR_S;
          burst.bytes[2] = info[7:0];
          burst.bytes[3] = info[15:8];
          if (nbytes == '0) begin
            // empty payload: trailer follows the header directly
            burst.bytes[4]       = sequence_count_next[7:0];
            burst.bytes[5]       = sequence_count_next[15:8];
            burst.bytes[6]       = CHAR_CR;
            burst.bytes[7]       = CHAR_LF;
            burst.last_idx       = 3'd7;
            burst.pkt_end        = 1'b1;
            packet_open_next     = 1'b0;
            bytes_remaining_next = '0;
          end else begin
            burst.last_idx       = 3'd3;
            packet_open_next     = 1'b1;
            bytes_remaining_next = REM_W'(nbytes);
          end
        end
      end
      KIND_DATA: begin
        if (!packet_open || bytes_remaining == '0) begin
          burst.status = STATUS_ORPHAN;
        end else begin
          bytes_remaining_next = bytes_remaining - REM_W'(1);
          burst.bytes[0]       = payload_byte;
          if (bytes_remaining_next == '0) begin
            burst.bytes[1]   = sequence_count[7:0];
            burst.bytes[2]   = sequence_count[15:8];
            burst.bytes[3]   = CHAR_CR;
            burst.bytes[4]   = CHAR_LF;
            burst.last_idx   = 3'd4;
            burst.pkt_end    = 1'b1;
            packet_open_next = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_count  <= '0;
      bytes_remaining <= '0;
      packet_open     <= 1'b0;
      pend_valid      <= 1'b0;
    end else begin
      if (accept) begin
        sequence_count  <= sequence_count_next;
        bytes_remaining <= bytes_remaining_next;
        packet_open     <= packet_open_next;
        pend_valid      <= 1'b1;
      end else if (take) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend <= burst;
    end
  end

endmodule

// ===== hw/rtl/tpf_emit.sv =====
// Output sequencer: plays out one burst a byte per transfer.
module tpf_emit
  import tpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pend_valid,
  input  burst_t     pend,
  output logic       take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] tx_byte,
  output logic       run_last,
  output logic       packet_end,
  output status_t    status
);

  burst_t     burst;
  logic [2:0] idx;
  logic       busy;
  logic       done;

  assign out_valid  = busy;
  assign run_last   = idx == burst.last_idx;
  assign tx_byte    = burst.bytes[idx];
  assign packet_end = burst.pkt_end && run_last;
  assign status     = burst.status;

  assign done = busy && out_ready && run_last;
  assign take = pend_valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (busy && out_ready) begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      burst <= pend;
    end
  end

endmodule

// ===== hw/rtl/typed_packet_framer.sv =====
// Top level of the typed packet framer.
// A begin transfer (tuser 0) opens a packet: it sends 'K', 'S' and the
// little-endian info word (type nibble OR payload byte count), then each data
// transfer (tuser 1) passes one payload byte, and the last one is followed by
// sequence low, sequence high, CR and LF. A bad type or oversize payload, and a
// data byte with no packet open, give one zero byte with an error status.
// Input and output are parted by a one-entry pending register, so an input can
// be taken while the previous burst is played out. Each input causes one output
// byte for a middle payload byte or an error, four for a header, five for the
// final payload byte with trailer and eight for an empty packet; the output
// port carries one byte per transfer.
module typed_packet_framer
  import tpf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // element_count[7:0], data_type[11:8], payload_byte[19:12]
  input  logic [0:0]  s_tuser,  // kind[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // tx_byte[7:0]
  output logic        m_tlast,
  output logic [2:0]  m_tuser   // packet_end[0], status[2:1]
);

  logic    take;
  logic    pend_valid;
  burst_t  pend;
  status_t status;
  logic    packet_end;

  tpf_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .kind          (kind_t'(s_tuser[0])),
    .element_count (s_tdata[7:0]),
    .data_type     (s_tdata[11:8]),
    .payload_byte  (s_tdata[19:12]),
    .take          (take),
    .pend_valid    (pend_valid),
    .pend          (pend)
  );

  tpf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .pend_valid (pend_valid),
    .pend       (pend),
    .take       (take),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .tx_byte    (m_tdata),
    .run_last   (m_tlast),
    .packet_end (packet_end),
    .status     (status)
  );

  assign m_tuser = {status, packet_end};

endmodule
